// File: rtl/core/htw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and placement function for the timer wheel.
package htw_pkg;
    localparam int NUM_TIMERS = 64;
    localparam int NEAR_BITS  = 8;
    localparam int LEVEL_BITS = 6;
    localparam int NUM_LEVELS = 4;
    localparam int TICK_BITS  = 32;
    localparam int SLOT_W     = 6;
    localparam int SLOT_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LVL_W      = 3;
    localparam int BKT_W      = 8;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_TICK   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  timer_slot;
        logic [31:0] deadline_tick;
    } in_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       expired_valid;
        logic [5:0] expired_slot;
        logic       last_result;
    } out_req_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [BKT_W-1:0] bucket;
    } place_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic                  load_req;
        logic                  do_add;
        logic                  do_remove;
        logic                  scan_clear;
        logic                  scan_expire;
        logic                  scan_cascade;
        logic                  scan_step;
        logic                  tick_advance;
    } htw_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic                  kind_add;
        logic                  kind_remove;
        logic                  kind_tick;
        logic                  slot_ok;
        logic                  slot_busy;
        logic                  scan_last;
        logic                  hit;
        logic [SLOT_W-1:0]     scan_slot;
    } htw_stat_t;

    function automatic place_t place_fn(input logic [TICK_BITS-1:0] d,
                                        input logic [TICK_BITS-1:0] ct);
        logic [TICK_BITS-1:0] diff;
        place_t               p;
        int                   lvl;
        diff = d ^ ct;
        p.level  = '0;
        p.bucket = BKT_W'(d[NEAR_BITS-1:0]);
        if ((diff >> NEAR_BITS) != '0) begin
            lvl = NUM_LEVELS - 1;
            for (int i = NUM_LEVELS - 2; i >= 0; i--) begin
                if ((diff >> (NEAR_BITS + (i + 1) * LEVEL_BITS)) == '0) begin
                    lvl = i;
                end
            end
            p.level  = LVL_W'(lvl + 1);
            p.bucket = BKT_W'((d >> (NEAR_BITS + lvl * LEVEL_BITS))
                              & ((1 << LEVEL_BITS) - 1));
        end
        return p;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/hierarchical_timer_wheel.sv
`timescale 1ns / 1ps
`default_nettype none
// Hierarchical timer wheel over 64 timer slots, scanned one slot per cycle.
// Add, remove: the request is registered and decoded, and its result passes through the pending
// register to the output register. Tick: decode, three 64-slot scans (expire, cascade, expire)
// and a flush step. The next request is taken once the pending result has moved to the output.
// An expire scan holds while both result registers are full and m_ready is low.
// Synchronous active-low reset empties all slots and zeroes the tick counter.
module hierarchical_timer_wheel (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire htw_pkg::in_req_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output htw_pkg::out_req_t      m_data
);
    import htw_pkg::*;

    htw_cmd_t  cmd;
    htw_stat_t stat;

    htw_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_in  (s_data),
        .cmd     (cmd),
        .stat    (stat)
    );

    htw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

    a_no_cmd_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.do_add && cmd.do_remove)) else $error("add and remove together");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.scan_expire || cmd.scan_cascade))
        else $error("request taken during scan");
    a_expired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.expired_valid) |-> m_data.status == ST_OK)
        else $error("expired result with error status");
endmodule
`default_nettype wire

// File: rtl/core/htw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Slot tables, tick counter and scan pointer of the timer wheel.
module htw_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire htw_pkg::in_req_t   req_in,
    input  wire htw_pkg::htw_cmd_t  cmd,
    output htw_pkg::htw_stat_t      stat
);
    import htw_pkg::*;

    logic [NUM_TIMERS-1:0]   in_use_reg;
    logic [TICK_BITS-1:0]    deadline_mem [NUM_TIMERS];
    place_t                  place_mem [NUM_TIMERS];
    place_t                  place_rd_reg;
    logic [TICK_BITS-1:0]    deadline_rd_reg;
    logic [TICK_BITS-1:0]    tick_reg;
    in_req_t                 req_reg;
    logic [SLOT_IDX_W-1:0]   ptr_reg;
    logic [SLOT_IDX_W-1:0]   ptr_next;
    logic [LVL_W-1:0]        cas_lvl_reg;
    logic [BKT_W-1:0]        cas_bkt_reg;
    logic                    cas_en_reg;
    logic [LVL_W-1:0]        cas_lvl_next;
    logic [BKT_W-1:0]        cas_bkt_next;
    logic                    cas_en_next;
    logic [TICK_BITS-1:0]    tick_next;
    logic                    hit;
    logic                    slot_ok;
    logic [SLOT_IDX_W-1:0]   req_idx;

    assign req_idx = SLOT_IDX_W'(req_reg.timer_slot);
    assign slot_ok = 32'(req_reg.timer_slot) < NUM_TIMERS;
    assign tick_next = tick_reg + 1'b1;

    // Read the slot tables at ptr_next so their registered data lines up with ptr_reg.
    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.load_req || cmd.scan_clear) begin
            ptr_next = '0;
        end else if (cmd.scan_step) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    // Pick the outer bucket to cascade after the roll-over.
    always_comb begin
        cas_en_next  = 1'b0;
        cas_lvl_next = '0;
        cas_bkt_next = '0;
        if (tick_next == '0) begin
            cas_en_next  = 1'b1;
            cas_lvl_next = LVL_W'(NUM_LEVELS);
        end else begin
            for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
                if (((tick_next & ((TICK_BITS'(1) << (NEAR_BITS + i * LEVEL_BITS)) - 1'b1))
                     == '0) &&
                    (((tick_next >> (NEAR_BITS + i * LEVEL_BITS))
                      & ((1 << LEVEL_BITS) - 1)) != '0)) begin
                    cas_en_next  = 1'b1;
                    cas_lvl_next = LVL_W'(i + 1);
                    cas_bkt_next = BKT_W'((tick_next >> (NEAR_BITS + i * LEVEL_BITS))
                                          & ((1 << LEVEL_BITS) - 1));
                end
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        if (in_use_reg[ptr_reg]) begin
            if (cmd.scan_cascade) begin
                hit = cas_en_reg && place_rd_reg.level == cas_lvl_reg &&
                      place_rd_reg.bucket == cas_bkt_reg;
            end else begin
                hit = place_rd_reg.level == '0 &&
                      place_rd_reg.bucket == BKT_W'(tick_reg[NEAR_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg  <= '0;
            tick_reg    <= '0;
            ptr_reg     <= '0;
            cas_en_reg  <= 1'b0;
        end else begin
            ptr_reg <= ptr_next;
            if (cmd.do_add) begin
                in_use_reg[req_idx] <= 1'b1;
            end
            if (cmd.do_remove) begin
                in_use_reg[req_idx] <= 1'b0;
            end
            if (cmd.scan_expire && hit) begin
                in_use_reg[ptr_reg] <= 1'b0;
            end
            if (cmd.tick_advance) begin
                tick_reg     <= tick_next;
                cas_en_reg   <= cas_en_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req_in;
        end
        if (cmd.tick_advance) begin
            cas_lvl_reg <= cas_lvl_next;
            cas_bkt_reg <= cas_bkt_next;
        end
        place_rd_reg    <= place_mem[ptr_next];
        deadline_rd_reg <= deadline_mem[ptr_next];
        if (cmd.do_add) begin
            deadline_mem[req_idx] <= req_reg.deadline_tick[TICK_BITS-1:0];
            place_mem[req_idx]    <= place_fn(req_reg.deadline_tick[TICK_BITS-1:0],
                                              tick_reg);
        end
        if (cmd.scan_cascade && hit) begin
            place_mem[ptr_reg] <= place_fn(deadline_rd_reg, tick_reg);
        end
    end

    always_comb begin
        stat.kind_add    = req_reg.kind == KIND_ADD;
        stat.kind_remove = req_reg.kind == KIND_REMOVE;
        stat.kind_tick   = req_reg.kind == KIND_TICK;
        stat.slot_ok     = slot_ok;
        stat.slot_busy   = in_use_reg[req_idx];
        stat.scan_last   = 32'(ptr_reg) == NUM_TIMERS - 1;
        stat.hit         = hit;
        stat.scan_slot   = SLOT_W'(ptr_reg);
    end
endmodule
`default_nettype wire

// File: rtl/core/htw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller sequencing requests, scan passes and result emission.
module htw_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output htw_pkg::out_req_t       m_data,
    output htw_pkg::htw_cmd_t       cmd,
    input  wire htw_pkg::htw_stat_t stat
);
    import htw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_EXP1, S_CASCADE, S_EXP2, S_FLUSH
    } state_t;

    state_t   state_reg, state_next;
    out_req_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;
    out_req_t pend_reg, pend_next;
    logic     pend_valid_reg, pend_valid_next;
    logic     room;

    // Hold an expire scan while a found slot cannot be buffered.
    assign room = !pend_valid_reg || !out_valid_reg || m_ready;
    assign s_ready = state_reg == S_IDLE && !pend_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next      = state_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cmd             = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                // Move a finished request result forward when the output frees.
                if (pend_valid_reg && (!out_valid_reg || m_ready)) begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                end
                if (s_valid && s_ready) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!pend_valid_reg) begin
                    if (stat.kind_tick) begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_EXP1;
                    end else begin
                        pend_next = '{status: ST_OK, expired_valid: 1'b0,
                                      expired_slot: '0, last_result: 1'b1};
                        if (stat.kind_add) begin
                            if (!stat.slot_ok || stat.slot_busy) begin
                                pend_next.status = ST_BUSY;
                            end else begin
                                cmd.do_add = 1'b1;
                            end
                        end else if (stat.kind_remove) begin
                            if (!stat.slot_ok || !stat.slot_busy) begin
                                pend_next.status = ST_EMPTY;
                            end else begin
                                cmd.do_remove = 1'b1;
                            end
                        end
                        pend_valid_next = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_EXP1, S_EXP2: begin
                // Keep the latest expiry held back until the next one or the end of the tick.
                if (room) begin
                    cmd.scan_expire = 1'b1;
                    cmd.scan_step   = 1'b1;
                    if (stat.hit) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next = '{status: ST_OK, expired_valid: 1'b1,
                                      expired_slot: stat.scan_slot,
                                      last_result: 1'b0};
                        pend_valid_next = 1'b1;
                    end
                    if (stat.scan_last) begin
                        cmd.scan_clear = 1'b1;
                        if (state_reg == S_EXP1) begin
                            cmd.tick_advance = 1'b1;
                            state_next       = S_CASCADE;
                        end else begin
                            state_next = S_FLUSH;
                        end
                    end
                end
            end
            S_CASCADE: begin
                cmd.scan_cascade = 1'b1;
                cmd.scan_step    = 1'b1;
                if (stat.scan_last) begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_EXP2;
                end
            end
            S_FLUSH: begin
                // Mark the held expiry as last, or report an empty tick.
                if (pend_valid_reg) begin
                    pend_next.last_result = 1'b1;
                end else begin
                    pend_next = '{status: ST_OK, expired_valid: 1'b0,
                                  expired_slot: '0, last_result: 1'b1};
                    pend_valid_next = 1'b1;
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end
endmodule
`default_nettype wire
